@@ design/cpdq_pkg.sv @@
// Shared types, constants, arithmetic helpers and micro-program for the quadrotor control core.
package cpdq_pkg;

  localparam int DW        = 32;
  localparam int FRAC      = 16;
  localparam int QW        = DW + FRAC;
  localparam int CNT_W     = $clog2(QW);
  localparam int CFG_IDX_W = 4;
  localparam int GW        = 31;
  localparam int NUM_GAINS = 8;
  localparam int PROG_LEN  = 60;
  localparam int PC_W      = $clog2(PROG_LEN);

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t FIX_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t FIX_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam fix_t FIX_ONE  = fix_t'(1) <<< FRAC;
  localparam fix_t FIX_MONE = -FIX_ONE;

  typedef struct packed {
    logic            req_type;
    fix_t            target_altitude;
    fix_t            target_x;
    fix_t            target_y;
    fix_t            target_yaw_rate;
    fix_t            meas_altitude;
    fix_t            meas_roll;
    fix_t            meas_pitch;
    fix_t            meas_yaw_rate;
    fix_t            meas_vx;
    fix_t            meas_vy;
    logic [GW-1:0]   step_time;
  } tick_t;

  typedef struct packed {
    fix_t motor_1;
    fix_t motor_2;
    fix_t motor_3;
    fix_t motor_4;
    fix_t pitch_setpoint;
    fix_t roll_setpoint;
  } motor_t;

  // Gain register indexes
  typedef enum logic [2:0] {
    GAIN_ALT_KP, GAIN_ALT_KD, GAIN_HOVER, GAIN_ATT_KP,
    GAIN_ATT_KD, GAIN_YAW_KP, GAIN_VEL_KP, GAIN_VEL_KD
  } gain_idx_t;

  typedef enum logic [2:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_CLAMP, OP_MUL, OP_DIV
  } op_t;

  typedef enum logic [5:0] {
    S_ZERO, S_TA, S_TX, S_TY, S_TYR, S_MA, S_MR, S_MP, S_MYR, S_MVX, S_MVY,
    S_G_AKP, S_G_AKD, S_G_HOVER, S_G_TKP, S_G_TKD, S_G_YKP, S_G_VKP, S_G_VKD,
    S_PA, S_PP, S_PR, S_PVX, S_PVY,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_PSP, S_RSP
  } src_t;

  typedef enum logic [4:0] {
    D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6,
    D_PA, D_PP, D_PR, D_PVX, D_PVY,
    D_PSP, D_RSP, D_M1, D_M2, D_M3, D_M4
  } dst_t;

  typedef enum logic [1:0] {W_ALL, W_VEL, W_ATT} when_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} ctrl_state_t;

  typedef struct packed {
    op_t   op;
    dst_t  dst;
    src_t  a;
    src_t  b;
    when_t when;
  } instr_t;

  typedef struct packed {
    logic   load;
    logic   issue;
    instr_t instr;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic done;
  } dp_status_t;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? FIX_MIN : FIX_MAX;
    return s[DW-1:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? FIX_MIN : FIX_MAX;
    return s[DW-1:0];
  endfunction

  function automatic fix_t clamp_one(fix_t e);
    if (e > FIX_ONE) return FIX_ONE;
    if (e < FIX_MONE) return FIX_MONE;
    return e;
  endfunction

  function automatic logic [DW-1:0] mag(fix_t a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  // Apply sign to a magnitude, saturating to the format
  function automatic fix_t sat_mag(logic neg, logic [QW-1:0] m);
    logic [QW-1:0] lim;
    logic [QW-1:0] v;
    lim = neg ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
    v = (m > lim) ? lim : m;
    return neg ? fix_t'(-v[DW-1:0]) : fix_t'(v[DW-1:0]);
  endfunction

  function automatic instr_t mk(op_t op, dst_t d, src_t a, src_t b, when_t w);
    instr_t i;
    i.op = op; i.dst = d; i.a = a; i.b = b; i.when = w;
    return i;
  endfunction

  // Micro-program: setpoint copy or velocity loops, then altitude, pitch, roll, yaw, then mixing
  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      6'd0:  i = mk(OP_MOV,   D_PSP, S_TX,      S_ZERO, W_ATT);
      6'd1:  i = mk(OP_MOV,   D_RSP, S_TY,      S_ZERO, W_ATT);
      6'd2:  i = mk(OP_SUB,   D_T0,  S_TX,      S_MVX,  W_VEL);
      6'd3:  i = mk(OP_SUB,   D_T1,  S_T0,      S_PVX,  W_VEL);
      6'd4:  i = mk(OP_DIV,   D_T1,  S_T1,      S_ZERO, W_VEL);
      6'd5:  i = mk(OP_CLAMP, D_T2,  S_T0,      S_ZERO, W_VEL);
      6'd6:  i = mk(OP_MUL,   D_T2,  S_G_VKP,   S_T2,   W_VEL);
      6'd7:  i = mk(OP_MUL,   D_T1,  S_G_VKD,   S_T1,   W_VEL);
      6'd8:  i = mk(OP_ADD,   D_PSP, S_T2,      S_T1,   W_VEL);
      6'd9:  i = mk(OP_MOV,   D_PVX, S_T0,      S_ZERO, W_VEL);
      6'd10: i = mk(OP_SUB,   D_T0,  S_TY,      S_MVY,  W_VEL);
      6'd11: i = mk(OP_SUB,   D_T1,  S_T0,      S_PVY,  W_VEL);
      6'd12: i = mk(OP_DIV,   D_T1,  S_T1,      S_ZERO, W_VEL);
      6'd13: i = mk(OP_CLAMP, D_T2,  S_T0,      S_ZERO, W_VEL);
      6'd14: i = mk(OP_MUL,   D_T2,  S_G_VKP,   S_T2,   W_VEL);
      6'd15: i = mk(OP_SUB,   D_T2,  S_ZERO,    S_T2,   W_VEL);
      6'd16: i = mk(OP_MUL,   D_T1,  S_G_VKD,   S_T1,   W_VEL);
      6'd17: i = mk(OP_SUB,   D_RSP, S_T2,      S_T1,   W_VEL);
      6'd18: i = mk(OP_MOV,   D_PVY, S_T0,      S_ZERO, W_VEL);
      6'd19: i = mk(OP_SUB,   D_T0,  S_TA,      S_MA,   W_ALL);
      6'd20: i = mk(OP_SUB,   D_T1,  S_T0,      S_PA,   W_ALL);
      6'd21: i = mk(OP_DIV,   D_T1,  S_T1,      S_ZERO, W_ALL);
      6'd22: i = mk(OP_CLAMP, D_T2,  S_T0,      S_ZERO, W_ALL);
      6'd23: i = mk(OP_MUL,   D_T2,  S_G_AKP,   S_T2,   W_ALL);
      6'd24: i = mk(OP_MUL,   D_T1,  S_G_AKD,   S_T1,   W_ALL);
      6'd25: i = mk(OP_ADD,   D_T2,  S_T2,      S_T1,   W_ALL);
      6'd26: i = mk(OP_ADD,   D_T3,  S_G_HOVER, S_T2,   W_ALL);
      6'd27: i = mk(OP_MOV,   D_PA,  S_T0,      S_ZERO, W_ALL);
      6'd28: i = mk(OP_SUB,   D_T0,  S_PSP,     S_MP,   W_ALL);
      6'd29: i = mk(OP_SUB,   D_T1,  S_T0,      S_PP,   W_ALL);
      6'd30: i = mk(OP_DIV,   D_T1,  S_T1,      S_ZERO, W_ALL);
      6'd31: i = mk(OP_CLAMP, D_T2,  S_T0,      S_ZERO, W_ALL);
      6'd32: i = mk(OP_MUL,   D_T2,  S_G_TKP,   S_T2,   W_ALL);
      6'd33: i = mk(OP_SUB,   D_T2,  S_ZERO,    S_T2,   W_ALL);
      6'd34: i = mk(OP_MUL,   D_T1,  S_G_TKD,   S_T1,   W_ALL);
      6'd35: i = mk(OP_SUB,   D_T4,  S_T2,      S_T1,   W_ALL);
      6'd36: i = mk(OP_MOV,   D_PP,  S_T0,      S_ZERO, W_ALL);
      6'd37: i = mk(OP_SUB,   D_T0,  S_RSP,     S_MR,   W_ALL);
      6'd38: i = mk(OP_SUB,   D_T1,  S_T0,      S_PR,   W_ALL);
      6'd39: i = mk(OP_DIV,   D_T1,  S_T1,      S_ZERO, W_ALL);
      6'd40: i = mk(OP_CLAMP, D_T2,  S_T0,      S_ZERO, W_ALL);
      6'd41: i = mk(OP_MUL,   D_T2,  S_G_TKP,   S_T2,   W_ALL);
      6'd42: i = mk(OP_MUL,   D_T1,  S_G_TKD,   S_T1,   W_ALL);
      6'd43: i = mk(OP_ADD,   D_T5,  S_T2,      S_T1,   W_ALL);
      6'd44: i = mk(OP_MOV,   D_PR,  S_T0,      S_ZERO, W_ALL);
      6'd45: i = mk(OP_SUB,   D_T0,  S_TYR,     S_MYR,  W_ALL);
      6'd46: i = mk(OP_CLAMP, D_T0,  S_T0,      S_ZERO, W_ALL);
      6'd47: i = mk(OP_MUL,   D_T6,  S_G_YKP,   S_T0,   W_ALL);
      6'd48: i = mk(OP_SUB,   D_T0,  S_T3,      S_T5,   W_ALL);
      6'd49: i = mk(OP_ADD,   D_T0,  S_T0,      S_T4,   W_ALL);
      6'd50: i = mk(OP_ADD,   D_M1,  S_T0,      S_T6,   W_ALL);
      6'd51: i = mk(OP_SUB,   D_T0,  S_T3,      S_T5,   W_ALL);
      6'd52: i = mk(OP_SUB,   D_T0,  S_T0,      S_T4,   W_ALL);
      6'd53: i = mk(OP_SUB,   D_M2,  S_T0,      S_T6,   W_ALL);
      6'd54: i = mk(OP_ADD,   D_T0,  S_T3,      S_T5,   W_ALL);
      6'd55: i = mk(OP_SUB,   D_T0,  S_T0,      S_T4,   W_ALL);
      6'd56: i = mk(OP_ADD,   D_M3,  S_T0,      S_T6,   W_ALL);
      6'd57: i = mk(OP_ADD,   D_T0,  S_T3,      S_T5,   W_ALL);
      6'd58: i = mk(OP_ADD,   D_T0,  S_T0,      S_T4,   W_ALL);
      6'd59: i = mk(OP_SUB,   D_M4,  S_T0,      S_T6,   W_ALL);
      default: i = mk(OP_MOV, D_T0,  S_ZERO,    S_ZERO, W_ALL);
    endcase
    return i;
  endfunction

endpackage

@@ design/cpdq_tick_if.sv @@
// Input channel carrying one control tick.
interface cpdq_tick_if;
  logic              valid;
  logic              ready;
  cpdq_pkg::tick_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/cpdq_motor_if.sv @@
// Output channel carrying the motor commands and setpoints.
interface cpdq_motor_if;
  logic              valid;
  logic              ready;
  cpdq_pkg::motor_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/cpdq_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface cpdq_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpdq_pkg::CFG_IDX_W-1:0]      index;
  logic [cpdq_pkg::GW-1:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/cpdq_datapath.sv @@
// Datapath: gain and error registers, saturating ALU, multiplier and bit-serial divider.
module cpdq_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  cpdq_pkg::tick_t       tick_data,
  cpdq_cfg_if.sink              cfg,
  input  cpdq_pkg::dp_cmd_t     cmd,
  output cpdq_pkg::dp_status_t  status,
  output cpdq_pkg::motor_t      result
);
  import cpdq_pkg::*;

  tick_t             in_r;
  logic [GW-1:0]     gain [NUM_GAINS];
  fix_t              prev_alt, prev_pitch, prev_roll, prev_vx, prev_vy;
  fix_t              t [7];
  fix_t              psp, rsp, m1, m2, m3, m4;
  motor_t            out_r;

  logic [2*DW-1:0]   prod;
  logic              mul_neg, mul_fin;
  logic [QW-1:0]     dvd, quo;
  logic [DW-2:0]     rem;
  logic [CNT_W-1:0]  cnt;
  logic              div_busy, div_fin, div_neg, div_zero;
  dst_t              dst_r;

  fix_t              op_a, op_b, alu_val, wb_val;
  logic              wb_en;
  dst_t              wb_dst;
  logic [DW-1:0]     rs;
  logic [DW-1:0]     dtz, diff;
  logic              ge;

  function automatic fix_t gval(gain_idx_t g);
    return fix_t'({1'b0, gain[g]});
  endfunction

  function automatic fix_t sel(src_t s);
    fix_t v;
    unique case (s)
      S_ZERO:    v = '0;
      S_TA:      v = in_r.target_altitude;
      S_TX:      v = in_r.target_x;
      S_TY:      v = in_r.target_y;
      S_TYR:     v = in_r.target_yaw_rate;
      S_MA:      v = in_r.meas_altitude;
      S_MR:      v = in_r.meas_roll;
      S_MP:      v = in_r.meas_pitch;
      S_MYR:     v = in_r.meas_yaw_rate;
      S_MVX:     v = in_r.meas_vx;
      S_MVY:     v = in_r.meas_vy;
      S_G_AKP:   v = gval(GAIN_ALT_KP);
      S_G_AKD:   v = gval(GAIN_ALT_KD);
      S_G_HOVER: v = gval(GAIN_HOVER);
      S_G_TKP:   v = gval(GAIN_ATT_KP);
      S_G_TKD:   v = gval(GAIN_ATT_KD);
      S_G_YKP:   v = gval(GAIN_YAW_KP);
      S_G_VKP:   v = gval(GAIN_VEL_KP);
      S_G_VKD:   v = gval(GAIN_VEL_KD);
      S_PA:      v = prev_alt;
      S_PP:      v = prev_pitch;
      S_PR:      v = prev_roll;
      S_PVX:     v = prev_vx;
      S_PVY:     v = prev_vy;
      S_T0:      v = t[0];
      S_T1:      v = t[1];
      S_T2:      v = t[2];
      S_T3:      v = t[3];
      S_T4:      v = t[4];
      S_T5:      v = t[5];
      S_T6:      v = t[6];
      S_PSP:     v = psp;
      S_RSP:     v = rsp;
      default:   v = '0;
    endcase
    return v;
  endfunction

  // Operand select and combinational ALU
  always_comb begin
    op_a = sel(cmd.instr.a);
    op_b = sel(cmd.instr.b);
    unique case (cmd.instr.op)
      OP_ADD:   alu_val = sat_add(op_a, op_b);
      OP_SUB:   alu_val = sat_sub(op_a, op_b);
      OP_CLAMP: alu_val = clamp_one(op_a);
      default:  alu_val = op_a;
    endcase
  end

  // Write-back select: multiplier and divider results win over the ALU
  always_comb begin
    wb_en  = mul_fin || div_fin ||
             (cmd.issue && cmd.instr.op != OP_MUL && cmd.instr.op != OP_DIV);
    wb_dst = (mul_fin || div_fin) ? dst_r : cmd.instr.dst;
    if (mul_fin) begin
      wb_val = sat_mag(mul_neg, prod[2*DW-1:FRAC]);
    end else if (div_fin) begin
      wb_val = div_zero ? '0 : sat_mag(div_neg, quo);
    end else begin
      wb_val = alu_val;
    end
  end

  assign status.mode = in_r.req_type;
  assign status.done = mul_fin || div_fin;
  assign result      = out_r;
  assign cfg.ready   = !rst;

  // Divider step: shift in one dividend bit, compare, subtract
  always_comb begin
    rs   = {rem, dvd[QW-1]};
    dtz  = {1'b0, in_r.step_time};
    ge   = (rs >= dtz);
    diff = rs - dtz;
  end

  // Gains and error history, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GAINS; i++) gain[i] <= '0;
      prev_alt   <= '0;
      prev_pitch <= '0;
      prev_roll  <= '0;
      prev_vx    <= '0;
      prev_vy    <= '0;
    end else begin
      if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_GAINS)) begin
        gain[cfg.index[2:0]] <= cfg.data;
      end
      if (wb_en) begin
        unique case (wb_dst)
          D_PA:    prev_alt   <= wb_val;
          D_PP:    prev_pitch <= wb_val;
          D_PR:    prev_roll  <= wb_val;
          D_PVX:   prev_vx    <= wb_val;
          D_PVY:   prev_vy    <= wb_val;
          default: ;
        endcase
      end
    end
  end

  // Working registers, latched tick and output beat
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= tick_data;
    if (wb_en) begin
      unique case (wb_dst)
        D_T0:    t[0] <= wb_val;
        D_T1:    t[1] <= wb_val;
        D_T2:    t[2] <= wb_val;
        D_T3:    t[3] <= wb_val;
        D_T4:    t[4] <= wb_val;
        D_T5:    t[5] <= wb_val;
        D_T6:    t[6] <= wb_val;
        D_PSP:   psp  <= wb_val;
        D_RSP:   rsp  <= wb_val;
        D_M1:    m1   <= wb_val;
        D_M2:    m2   <= wb_val;
        D_M3:    m3   <= wb_val;
        D_M4:    m4   <= wb_val;
        default: ;
      endcase
    end
    if (cmd.publish) begin
      out_r.motor_1        <= m1;
      out_r.motor_2        <= m2;
      out_r.motor_3        <= m3;
      out_r.motor_4        <= m4;
      out_r.pitch_setpoint <= psp;
      out_r.roll_setpoint  <= rsp;
    end
  end

  // Multiplier: register magnitude product, saturate next cycle
  always_ff @(posedge clk) begin
    if (cmd.issue && cmd.instr.op == OP_MUL) begin
      prod    <= mag(op_a) * mag(op_b);
      mul_neg <= op_a[DW-1] ^ op_b[DW-1];
    end
    if (cmd.issue) dst_r <= cmd.instr.dst;
  end

  // Divider datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.issue && cmd.instr.op == OP_DIV) begin
      dvd      <= {mag(op_a), {FRAC{1'b0}}};
      quo      <= '0;
      rem      <= '0;
      div_neg  <= op_a[DW-1];
      div_zero <= (op_a == '0);
    end else if (div_busy) begin
      dvd <= dvd << 1;
      quo <= {quo[QW-2:0], ge};
      rem <= ge ? diff[DW-2:0] : rs[DW-2:0];
    end
  end

  // Unit control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_fin  <= 1'b0;
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
      cnt      <= '0;
    end else begin
      mul_fin <= cmd.issue && cmd.instr.op == OP_MUL;
      div_fin <= 1'b0;
      if (cmd.issue && cmd.instr.op == OP_DIV) begin
        div_busy <= 1'b1;
        cnt      <= '0;
      end else if (div_busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QW-1)) begin
          div_busy <= 1'b0;
          div_fin  <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fin_excl: assert property (@(posedge clk) disable iff (rst)
    !(mul_fin && div_fin))
    else $error("multiplier and divider finished together");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.instr.op == OP_DIV |=> div_busy && cnt == '0)
    else $error("divider did not start");
  a_no_issue_busy: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !cmd.issue)
    else $error("instruction issued while divider busy");
`endif

endmodule

@@ design/cpdq_ctrl.sv @@
// Controller: steps the micro-program and runs the tick and result handshakes.
module cpdq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cpdq_pkg::dp_cmd_t     cmd,
  input  cpdq_pkg::dp_status_t  status
);
  import cpdq_pkg::*;

  ctrl_state_t      state, state_next;
  logic [PC_W-1:0]  pc, pc_next;
  logic             out_valid_next;
  instr_t           ins;
  logic             skip, last;

  // Hold state, program counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequence instructions; multiply and divide wait for the unit
  always_comb begin
    ins            = prog(pc);
    skip           = (ins.when == W_VEL && !status.mode) ||
                     (ins.when == W_ATT && status.mode);
    last           = (pc == PC_W'(PROG_LEN-1));
    state_next     = state;
    pc_next        = pc;
    tick_ready     = 1'b0;
    cmd.load       = 1'b0;
    cmd.issue      = 1'b0;
    cmd.instr      = ins;
    cmd.publish    = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        tick_ready = !rst;
        if (tick_valid && !rst) begin
          cmd.load   = 1'b1;
          pc_next    = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!skip) cmd.issue = 1'b1;
        if (!skip && (ins.op == OP_MUL || ins.op == OP_DIV)) begin
          state_next = ST_WAIT;
        end else if (last) begin
          state_next = ST_DONE;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      ST_WAIT: begin
        if (status.done) begin
          if (last) begin
            state_next = ST_DONE;
          end else begin
            pc_next    = pc + 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_start: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> state == ST_RUN && pc == '0)
    else $error("tick beat did not start the program");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == ST_WAIT)
    else $error("unit finished outside a wait");
  a_publish: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid && state == ST_IDLE)
    else $error("published result not presented");
`endif

endmodule

@@ design/cascaded_pd_quadrotor_control_core.sv @@
// Cascaded PD quadrotor control core with X motor mixing, Q16.16.
// Run time per tick is set by the bit-serial divider: three divides per tick in attitude mode
// and five in velocity mode. A new tick is taken only once the previous result is registered.
// Reset (rst, synchronous): gains and stored errors clear to zero, no result pending.
module cascaded_pd_quadrotor_control_core (
  input  logic  clk,
  input  logic  rst,
  cpdq_tick_if.sink     tick,
  cpdq_cfg_if.sink      cfg,
  cpdq_motor_if.source  motor
);
  import cpdq_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;

  cpdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .out_valid  (motor.valid),
    .out_ready  (motor.ready),
    .cmd        (cmd),
    .status     (status)
  );

  cpdq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .tick_data (tick.data),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .result    (motor.data)
  );

endmodule
